// File: rtl/core/buddy_block_allocator_defines.svh
// Assertion macros shared by the buddy allocator RTL.
`ifndef BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked only out of reset.
`define BBA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only out of reset.
`define BBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/bba_pkg.sv
// Package with constants, types and helper functions of the buddy allocator.
`timescale 1ns / 1ps
package bba_pkg;

    localparam int TOP_BLOCKS   = 16;
    localparam int MAX_CLASS    = 7;
    localparam int MIN_SHIFT    = 5;
    localparam int HEADER_BYTES = 8;

    localparam int WORD_BITS   = 32;
    localparam int MIN_BLOCKS  = TOP_BLOCKS << MAX_CLASS;
    localparam int MAP_BITS    = TOP_BLOCKS * ((2 << MAX_CLASS) - 1);
    localparam int MAP_WORDS   = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int TOP_MASK    = (1 << TOP_BLOCKS) - 1;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_NO_MEM   = 2'd1;
    localparam status_t ST_TOO_BIG  = 2'd2;
    localparam status_t ST_BAD_FREE = 2'd3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_A_RD,
        S_A_CHK,
        S_A_SPL_RD,
        S_A_SPL_WR,
        S_A_TAG,
        S_F_TAG_RD,
        S_F_TAG_CHK,
        S_F_MRG_RD,
        S_F_MRG_CHK,
        S_F_SET_RD,
        S_F_SET_WR,
        S_DONE
    } state_t;

    typedef struct packed {
        logic       found;
        logic [4:0] idx;
    } low_bit_t;

    // Number of bitmap words that hold one class level.
    function automatic logic [6:0] level_words(input logic [2:0] lvl);
        int n;
        n = (TOP_BLOCKS << (MAX_CLASS - int'(lvl))) / WORD_BITS;
        if (n < 1) begin
            n = 1;
        end
        return 7'(n);
    endfunction

    // First bitmap word of a class level; every level starts on a word.
    function automatic logic [6:0] level_base(input logic [2:0] lvl);
        int b;
        b = 0;
        for (int k = 0; k < MAX_CLASS; k++) begin
            if (k < int'(lvl)) begin
                b = b + int'(level_words(3'(k)));
            end
        end
        return 7'(b);
    endfunction

    // Smallest class whose block holds the request plus its header.
    function automatic logic [3:0] size_class(input logic [16:0] need);
        logic [3:0] c;
        c = 4'(MAX_CLASS + 1);
        for (int k = MAX_CLASS; k >= 0; k--) begin
            if ((17'd1 << (MIN_SHIFT + k)) >= need) begin
                c = 4'(k);
            end
        end
        return c;
    endfunction

endpackage

// File: rtl/core/bba_find_low.sv
// Priority encoder that finds the lowest set bit of one bitmap word.
`timescale 1ns / 1ps
module bba_find_low
    import bba_pkg::*;
(
    input  logic [WORD_BITS-1:0] word_i,
    output low_bit_t             low_o
);

    always_comb begin
        low_o.found = 1'b0;
        low_o.idx   = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (word_i[i]) begin
                low_o.found = 1'b1;
                low_o.idx   = 5'(i);
            end
        end
    end

endmodule

// File: rtl/core/buddy_block_allocator.sv
// Buddy allocator top level: handshake, sequencer, free bitmap and class tag memories.
// Allocates and frees blocks of 32 to 4096 bytes from a 64 KiB pool of sixteen
// top blocks. After reset the block runs a clearing pass over all 2048 class tag
// entries before s_tready first rises. Each item then works through the single
// read port of the free bitmap (128 words of 32 bits).
// An allocate whose request is too large is refused without a bitmap read. Any other
// allocate scans the words of its class and of larger classes from the lowest
// address, then splits the block it finds down to its class. A free checks and
// merges buddies upward, or is refused on a bad address or tag. One item is worked
// on at a time; the result sits in an output register, and the next beat is taken
// once the result has moved there.
`timescale 1ns / 1ps
`include "buddy_block_allocator_defines.svh"
module buddy_block_allocator
    import bba_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] request_length, [31:16] payload_address
    input  logic        s_tuser,   // [0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [1:0] status, [17:2] result_address,
                                   // [20:18] granted_class, [23:21] zero
);

    logic [WORD_BITS-1:0] fm_mem [MAP_WORDS];
    logic [3:0]           ct_mem [MIN_BLOCKS];

    state_t state_reg, state_next;
    logic [10:0] clr_reg, clr_next;
    logic        op_reg, op_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] pa_reg, pa_next;
    logic [2:0]  cls_reg, cls_next;
    logic [2:0]  lvl_reg, lvl_next;
    logic [5:0]  word_reg, word_next;
    logic [10:0] bi_reg, bi_next;
    logic [10:0] mi_reg, mi_next;
    status_t     res_st_reg, res_st_next;
    logic [15:0] res_addr_reg, res_addr_next;
    logic [2:0]  res_cls_reg, res_cls_next;
    logic        m_valid_reg, m_valid_next;
    status_t     m_st_reg, m_st_next;
    logic [15:0] m_addr_reg, m_addr_next;
    logic [2:0]  m_cls_reg, m_cls_next;

    logic [6:0]           fm_raddr, fm_waddr;
    logic                 fm_we;
    logic [WORD_BITS-1:0] fm_wdata, fm_rdata;
    logic [10:0]          ct_raddr, ct_waddr;
    logic                 ct_we;
    logic [3:0]           ct_wdata, ct_rdata;
    low_bit_t             low;

    logic [16:0] need;
    logic [3:0]  want;
    logic [10:0] idx_full, buddy, shifted;
    logic [15:0] blk;
    logic [3:0]  tag;
    logic [6:0]  lvl_words;

    bba_find_low u_find_low (
        .word_i (fm_rdata),
        .low_o  (low)
    );

    always_ff @(posedge aclk) begin
        if (fm_we) begin
            fm_mem[fm_waddr] <= fm_wdata;
        end
        fm_rdata <= fm_mem[fm_raddr];
        if (ct_we) begin
            ct_mem[ct_waddr] <= ct_wdata;
        end
        ct_rdata <= ct_mem[ct_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg       <= op_next;
        len_reg      <= len_next;
        pa_reg       <= pa_next;
        cls_reg      <= cls_next;
        lvl_reg      <= lvl_next;
        word_reg     <= word_next;
        bi_reg       <= bi_next;
        mi_reg       <= mi_next;
        res_st_reg   <= res_st_next;
        res_addr_reg <= res_addr_next;
        res_cls_reg  <= res_cls_next;
        m_st_reg     <= m_st_next;
        m_addr_reg   <= m_addr_next;
        m_cls_reg    <= m_cls_next;
    end

    assign need      = {1'b0, len_reg} + 17'(HEADER_BYTES);
    assign want      = size_class(need);
    assign idx_full  = {word_reg, low.idx};
    assign buddy     = bi_reg ^ 11'd1;
    assign shifted   = bi_reg << cls_reg;
    assign blk       = pa_reg - 16'(HEADER_BYTES);
    assign tag       = ct_rdata;
    assign lvl_words = level_words(lvl_reg);

    always_comb begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        op_next       = op_reg;
        len_next      = len_reg;
        pa_next       = pa_reg;
        cls_next      = cls_reg;
        lvl_next      = lvl_reg;
        word_next     = word_reg;
        bi_next       = bi_reg;
        mi_next       = mi_reg;
        res_st_next   = res_st_reg;
        res_addr_next = res_addr_reg;
        res_cls_next  = res_cls_reg;
        m_valid_next  = m_valid_reg;
        m_st_next     = m_st_reg;
        m_addr_next   = m_addr_reg;
        m_cls_next    = m_cls_reg;
        s_tready      = 1'b0;
        fm_raddr      = '0;
        fm_we         = 1'b0;
        fm_waddr      = '0;
        fm_wdata      = '0;
        ct_raddr      = '0;
        ct_we         = 1'b0;
        ct_waddr      = '0;
        ct_wdata      = '0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR: begin
                ct_we    = 1'b1;
                ct_waddr = clr_reg;
                if (clr_reg < 11'(MAP_WORDS)) begin
                    fm_we    = 1'b1;
                    fm_waddr = clr_reg[6:0];
                    fm_wdata = (clr_reg[6:0] == level_base(3'(MAX_CLASS))) ?
                               WORD_BITS'(TOP_MASK) : '0;
                end
                clr_next = clr_reg + 11'd1;
                if (clr_reg == 11'(MIN_BLOCKS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    op_next  = s_tuser;
                    len_next = s_tdata[15:0];
                    pa_next  = s_tdata[31:16];
                    state_next = (s_tuser == OP_FREE) ? S_F_TAG_RD : S_A_RD;
                    lvl_next  = '0;
                    word_next = '0;
                end
            end
            S_A_RD: begin
                // First pass through here settles the wanted class.
                if (want > 4'(MAX_CLASS)) begin
                    res_st_next   = ST_TOO_BIG;
                    res_addr_next = '0;
                    res_cls_next  = '0;
                    state_next    = S_DONE;
                end else begin
                    if (word_reg == '0 && lvl_reg == '0) begin
                        cls_next = want[2:0];
                        lvl_next = want[2:0];
                        fm_raddr = level_base(want[2:0]);
                    end else begin
                        fm_raddr = level_base(lvl_reg) + 7'(word_reg);
                    end
                    state_next = S_A_CHK;
                end
            end
            S_A_CHK: begin
                if (low.found) begin
                    fm_we    = 1'b1;
                    fm_waddr = level_base(lvl_reg) + 7'(word_reg);
                    fm_wdata = fm_rdata & ~(WORD_BITS'(1) << low.idx);
                    if (lvl_reg == cls_reg) begin
                        bi_next    = idx_full;
                        state_next = S_A_TAG;
                    end else begin
                        bi_next    = idx_full << 1;
                        lvl_next   = lvl_reg - 3'd1;
                        state_next = S_A_SPL_RD;
                    end
                end else if ({1'b0, word_reg} + 7'd1 == lvl_words) begin
                    if (lvl_reg == 3'(MAX_CLASS)) begin
                        res_st_next   = ST_NO_MEM;
                        res_addr_next = '0;
                        res_cls_next  = '0;
                        state_next    = S_DONE;
                    end else begin
                        lvl_next   = lvl_reg + 3'd1;
                        word_next  = '0;
                        state_next = S_A_RD;
                    end
                end else begin
                    word_next  = word_reg + 6'd1;
                    state_next = S_A_RD;
                end
            end
            S_A_SPL_RD: begin
                fm_raddr   = level_base(lvl_reg) + 7'(bi_reg[10:5]);
                state_next = S_A_SPL_WR;
            end
            S_A_SPL_WR: begin
                // The upper half of each split becomes free.
                fm_we    = 1'b1;
                fm_waddr = level_base(lvl_reg) + 7'(bi_reg[10:5]);
                fm_wdata = fm_rdata | (WORD_BITS'(1) << (bi_reg[4:0] | 5'd1));
                if (lvl_reg == cls_reg) begin
                    state_next = S_A_TAG;
                end else begin
                    bi_next    = bi_reg << 1;
                    lvl_next   = lvl_reg - 3'd1;
                    state_next = S_A_SPL_RD;
                end
            end
            S_A_TAG: begin
                ct_we         = 1'b1;
                ct_waddr      = shifted;
                ct_wdata      = {1'b0, cls_reg} + 4'd1;
                res_st_next   = ST_OK;
                res_addr_next = (16'(bi_reg) << (5'(MIN_SHIFT) + 5'(cls_reg)))
                                + 16'(HEADER_BYTES);
                res_cls_next  = cls_reg;
                state_next    = S_DONE;
            end
            S_F_TAG_RD: begin
                if (pa_reg < 16'(HEADER_BYTES) || blk[MIN_SHIFT-1:0] != '0) begin
                    res_st_next   = ST_BAD_FREE;
                    res_addr_next = '0;
                    res_cls_next  = '0;
                    state_next    = S_DONE;
                end else begin
                    ct_raddr   = blk[15:MIN_SHIFT];
                    mi_next    = blk[15:MIN_SHIFT];
                    state_next = S_F_TAG_CHK;
                end
            end
            S_F_TAG_CHK: begin
                if (tag == 4'd0 || tag > 4'(MAX_CLASS + 1)) begin
                    res_st_next   = ST_BAD_FREE;
                    res_addr_next = '0;
                    res_cls_next  = '0;
                    state_next    = S_DONE;
                end else begin
                    ct_we      = 1'b1;
                    ct_waddr   = mi_reg;
                    ct_wdata   = '0;
                    cls_next   = 3'(tag - 4'd1);
                    lvl_next   = 3'(tag - 4'd1);
                    bi_next    = mi_reg >> (tag - 4'd1);
                    state_next = (tag == 4'(MAX_CLASS + 1)) ? S_F_SET_RD : S_F_MRG_RD;
                end
            end
            S_F_MRG_RD: begin
                fm_raddr   = level_base(lvl_reg) + 7'(buddy[10:5]);
                state_next = S_F_MRG_CHK;
            end
            S_F_MRG_CHK: begin
                if (fm_rdata[buddy[4:0]]) begin
                    fm_we    = 1'b1;
                    fm_waddr = level_base(lvl_reg) + 7'(buddy[10:5]);
                    fm_wdata = fm_rdata & ~(WORD_BITS'(1) << buddy[4:0]);
                    bi_next  = bi_reg >> 1;
                    lvl_next = lvl_reg + 3'd1;
                    state_next = (lvl_reg + 3'd1 == 3'(MAX_CLASS)) ? S_F_SET_RD
                                                                   : S_F_MRG_RD;
                end else begin
                    state_next = S_F_SET_RD;
                end
            end
            S_F_SET_RD: begin
                fm_raddr   = level_base(lvl_reg) + 7'(bi_reg[10:5]);
                state_next = S_F_SET_WR;
            end
            S_F_SET_WR: begin
                fm_we         = 1'b1;
                fm_waddr      = level_base(lvl_reg) + 7'(bi_reg[10:5]);
                fm_wdata      = fm_rdata | (WORD_BITS'(1) << bi_reg[4:0]);
                res_st_next   = ST_OK;
                res_addr_next = '0;
                res_cls_next  = cls_reg;
                state_next    = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_st_next    = res_st_reg;
                    m_addr_next  = res_addr_reg;
                    m_cls_next   = res_cls_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_cls_reg, m_addr_reg, m_st_reg};

    `BBA_ASSERT_NEXT(a_busy_after_beat, s_tvalid && s_tready, !s_tready, "ready after accept")
    `BBA_ASSERT_NOW(a_err_zero, m_valid_reg && m_st_reg != ST_OK, m_addr_reg == '0 && m_cls_reg == '0, "error result carries data")
    `BBA_ASSERT_NOW(a_clear_blocks, state_reg == S_CLEAR, !s_tready && !m_valid_reg, "input taken during clearing")

endmodule

// File: test/tb.sv
// Self-checking stream testbench for the buddy block allocator.
`timescale 1ns / 1ps
module tb;
    import bba_pkg::*;

    localparam int POOL_BYTES = TOP_BLOCKS << (MIN_SHIFT + MAX_CLASS);
    localparam int LVL_BITS   = TOP_BLOCKS * ((2 << MAX_CLASS) - 1);

    typedef struct packed {
        logic        op;
        logic [15:0] len;
        logic [15:0] addr;
    } request_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] address;
        logic [2:0]  cls;
    } grant_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    buddy_block_allocator dut (.*);

    always #6 aclk = ~aclk;

    // Predictor state: one free bit per block of every class, class+1 per minimum block.
    logic       block_free [LVL_BITS];
    logic [3:0] owner_class [MIN_BLOCKS];
    logic [15:0] live_addrs [$];

    request_t pending_requests [$];
    grant_t   expected_grants [$];
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    bit       hold_sender = 1'b0;
    bit       any_failure = 1'b0;

    function automatic int level_start(int c);
        int b;
        b = 0;
        for (int k = 0; k < c; k++) b += TOP_BLOCKS << (MAX_CLASS - k);
        return b;
    endfunction

    function automatic grant_t predict_grant(request_t rq);
        grant_t g;
        int need, c, lvl, idx, blk, mi;
        g = '0;
        if (rq.op == OP_ALLOC) begin
            need = int'(rq.len) + HEADER_BYTES;
            c = 0;
            while (c <= MAX_CLASS && (1 << (MIN_SHIFT + c)) < need) c++;
            if (c > MAX_CLASS) begin
                g.status = ST_TOO_BIG;
                return g;
            end
            idx = -1;
            for (lvl = c; lvl <= MAX_CLASS; lvl++) begin
                for (int i = 0; i < (TOP_BLOCKS << (MAX_CLASS - lvl)); i++)
                    if (idx < 0 && block_free[level_start(lvl) + i]) idx = i;
                if (idx >= 0) break;
            end
            if (idx < 0) begin
                g.status = ST_NO_MEM;
                return g;
            end
            block_free[level_start(lvl) + idx] = 1'b0;
            while (lvl > c) begin
                lvl--;
                idx = idx << 1;
                block_free[level_start(lvl) + (idx | 1)] = 1'b1;
            end
            owner_class[(idx << c) % MIN_BLOCKS] = 4'(c + 1);
            g.status = ST_OK;
            g.address = 16'((idx << (MIN_SHIFT + c)) + HEADER_BYTES);
            g.cls = 3'(c);
            live_addrs.push_back(g.address);
        end else begin
            g.status = ST_BAD_FREE;
            if (rq.addr < HEADER_BYTES) return g;
            blk = int'(rq.addr) - HEADER_BYTES;
            if (blk >= POOL_BYTES || (blk % (1 << MIN_SHIFT)) != 0) return g;
            mi = blk >> MIN_SHIFT;
            if (owner_class[mi] == 0 || owner_class[mi] > MAX_CLASS + 1) return g;
            c = owner_class[mi] - 1;
            g.status = ST_OK;
            g.cls = 3'(c);
            owner_class[mi] = 0;
            idx = mi >> c;
            while (c < MAX_CLASS && block_free[level_start(c) + (idx ^ 1)]) begin
                block_free[level_start(c) + (idx ^ 1)] = 1'b0;
                idx = idx >> 1;
                c++;
            end
            block_free[level_start(c) + idx] = 1'b1;
        end
        return g;
    endfunction

    // Driver: a beat stays on the bus until the allocator takes it.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_grants.push_back(predict_grant(pending_requests.pop_front()));
            end
            if ((!s_tvalid || s_tready)) begin
                if (pending_requests.size() > (s_tvalid && s_tready ? 0 : 0) &&
                    !hold_sender && $urandom_range(99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tuser  <= pending_requests[0].op;
                    s_tdata  <= {pending_requests[0].addr, pending_requests[0].len};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: compare each result beat against the oldest prediction.
    always @(posedge aclk) begin
        grant_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_grants.size() == 0) begin
                $error("result beat with no request outstanding: %h", m_tdata);
                any_failure = 1'b1;
            end else begin
                want = expected_grants.pop_front();
                if (m_tdata[1:0] !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tdata[1:0]);
                    any_failure = 1'b1;
                end
                if (m_tdata[17:2] !== want.address) begin
                    $error("result_address: expected %h, got %h", want.address,
                           m_tdata[17:2]);
                    any_failure = 1'b1;
                end
                if (m_tdata[20:18] !== want.cls) begin
                    $error("granted_class: expected %0d, got %0d", want.cls,
                           m_tdata[20:18]);
                    any_failure = 1'b1;
                end
            end
        end
    end

    task automatic queue_req(logic op, logic [15:0] len, logic [15:0] addr);
        request_t rq;
        rq.op = op;
        rq.len = len;
        rq.addr = addr;
        pending_requests.push_back(rq);
    endtask

    // Free addresses come mostly from live allocations so merges really happen.
    task automatic queue_random(int count);
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
                if ($urandom_range(9) == 0) queue_req(OP_ALLOC, 16'($urandom), 16'($urandom));
                else queue_req(OP_ALLOC, 16'($urandom_range(1 << $urandom_range(12, 4))),
                               16'($urandom));
            end else if (pick < 90 && live_addrs.size() > 0) begin
                // Predictor runs later, so pick from addresses seen so far.
                queue_req(OP_FREE, 16'($urandom),
                          live_addrs[$urandom_range(live_addrs.size() - 1)]);
            end else if (pick < 95) begin
                queue_req(OP_FREE, 16'($urandom), 16'($urandom_range(POOL_BYTES / 32 - 1) * 32
                                                     + HEADER_BYTES));
            end else begin
                queue_req(OP_FREE, 16'($urandom), 16'($urandom));
            end
        end
    endtask

    task automatic drain();
        while (pending_requests.size() > 0 || s_tvalid || expected_grants.size() > 0)
            @(posedge aclk);
    endtask

    initial begin
        for (int i = 0; i < LVL_BITS; i++) block_free[i] = (i >= level_start(MAX_CLASS));
        for (int i = 0; i < MIN_BLOCKS; i++) owner_class[i] = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: classes 0, 1 and 7, too large, exhaustion, bad frees, merges, double free.
        queue_req(OP_ALLOC, 16'd0, 16'hFFFF);
        queue_req(OP_ALLOC, 16'd24, 16'd0);
        queue_req(OP_ALLOC, 16'd25, 16'd0);
        queue_req(OP_ALLOC, 16'd4088, 16'd0);
        queue_req(OP_ALLOC, 16'd4089, 16'd0);
        queue_req(OP_ALLOC, 16'hFFFF, 16'd0);
        queue_req(OP_FREE, 16'hFFFF, 16'd8);
        queue_req(OP_FREE, 16'd0, 16'd8);
        queue_req(OP_FREE, 16'd0, 16'd0);
        queue_req(OP_FREE, 16'd0, 16'd7);
        queue_req(OP_FREE, 16'd0, 16'd9);
        queue_req(OP_FREE, 16'd0, 16'hFFFF);
        queue_req(OP_FREE, 16'd0, 16'd40);
        queue_req(OP_FREE, 16'd0, 16'd72);
        for (int i = 0; i < 17; i++) queue_req(OP_ALLOC, 16'd3000, 16'd0);
        queue_req(OP_ALLOC, 16'd1, 16'd0);
        drain();
        for (int i = 0; i < 16; i++) queue_req(OP_FREE, 16'd0, 16'(i * 4096 + 8));
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1 || ph == 3) ? (ph == 3 ? 8 : 55) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 3 ? 8 : 55) : 0;
            if (ph == 1) send_idle_pct = 55;
            for (int k = 0; k < 5; k++) begin
                queue_random(50);
                drain();
            end
            hold_sender = 1'b1;
            drain();
            hold_sender = 1'b0;
        end
        drain();
        repeat (300) @(posedge aclk);
        if (!any_failure) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end

    initial begin
        #50ms;
        $display("Test completed with failures");
        $finish;
    end
endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/bba_pkg.sv
rtl/core/bba_find_low.sv
rtl/core/buddy_block_allocator.sv
test/tb.sv
